// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CLBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("Concurrent assertion failed.");

// Next-cycle implication, disabled while reset is active.
`define CLBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("Concurrent assertion failed.");

// Condition that must hold in the cycle after a reset cycle.
`define CLBS_ASSERT_RST(label, clk, rst_n, cons) \
    label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("Concurrent assertion failed.");

`endif

// ----- sv/clbs_pkg.sv -----
// ----------------------------------------------------------------------------
// clbs_pkg
// Types, widths, codes and helper functions of the charger load-balance
// sequencer.
// ----------------------------------------------------------------------------
package clbs_pkg;

    localparam int PHASE_COUNT_DEF = 3;

    localparam int FUSE_W    = 17;
    localparam int MAINS_W   = 17;
    localparam int CHARGER_W = 16;
    localparam int IVAL_W    = 16;
    localparam int TIME_W    = 32;
    localparam int LIMIT_W   = 18;
    localparam int WORD_W    = 16;
    localparam int CAND_W    = 19;
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam int FUSE_RESET          = 25000;
    localparam int POLL_RESET          = 1000;
    localparam int METER_TIMEOUT_RESET = 10000;
    localparam logic [TIME_W-1:0] LAST_FRAME_RESET = TIME_W'(-METER_TIMEOUT_RESET);

    localparam int CHARGE_ON_THRESH = 1000;
    localparam int MA_PER_A  = 1000;
    localparam int DIV_SHIFT = 27;
    localparam int RECIP_W   = 18;
    localparam logic [RECIP_W-1:0] MA_RECIP =
        RECIP_W'(((2 ** DIV_SHIFT) + MA_PER_A - 1) / MA_PER_A);

    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_FRAME    = 2'd1;
    localparam logic [1:0] KIND_ANSWER   = 2'd2;
    localparam logic [1:0] KIND_RESERVED = 2'd3;

    localparam logic [1:0] ANS_OK   = 2'd0;
    localparam logic [1:0] ANS_BUSY = 2'd1;

    localparam logic [1:0] REQ_NONE  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_KEEP  = 2'd2;
    localparam logic [1:0] REQ_LIMIT = 2'd3;

    localparam logic [1:0] REG_FUSE    = 2'd0;
    localparam logic [1:0] REG_POLL    = 2'd1;
    localparam logic [1:0] REG_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [1:0]           kind;
        logic [MAINS_W-1:0]   mains_current_l1;
        logic [MAINS_W-1:0]   mains_current_l2;
        logic [MAINS_W-1:0]   mains_current_l3;
        logic [1:0]           answer_code;
        logic [CHARGER_W-1:0] charger_word_l1;
        logic [CHARGER_W-1:0] charger_word_l2;
        logic [CHARGER_W-1:0] charger_word_l3;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                issue_request;
        logic [WORD_W-1:0]         limit_word;
        logic signed [LIMIT_W-1:0] limit_ma_now;
        logic                      connected;
        logic                      connected_changed;
    } out_item_t;

    typedef struct packed {
        logic [FUSE_W-1:0] fuse_cap;
        logic [IVAL_W-1:0] poll_interval_ms;
        logic [IVAL_W-1:0] meter_timeout_ms;
    } cfg_t;

    function automatic logic [15:0] swap16(input logic [15:0] v);
        return {v[7:0], v[15:8]};
    endfunction

endpackage

// ----- sv/charger_load_balance_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// charger_load_balance_sequencer_core
// Poll sequencer for a charger link with mains-based load balancing.
//
//   Channel   Handshake              Payload
//   s_        s_valid / s_ready      clbs_pkg::in_item_t   (tick, frame, answer)
//   m_        m_valid / m_ready      clbs_pkg::out_item_t  (one per transaction)
//   cfg       psel/penable/pready    fuse, poll interval, meter timeout
//
// Each transaction passes an input register and a result register; one
// transaction is taken per cycle while the result register is not stalled.
// The rate is set by the combinational update path from the input register.
// Reset is synchronous and active low.
// When m_ready is low, one transaction waits in the input register before
// s_ready drops.
// ----------------------------------------------------------------------------
module charger_load_balance_sequencer_core #(
    parameter int PHASE_COUNT = clbs_pkg::PHASE_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  clbs_pkg::in_item_t           s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output clbs_pkg::out_item_t          m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [clbs_pkg::ADDR_W-1:0]  paddr,
    input  logic [clbs_pkg::DATA_W-1:0]  pwdata,
    output logic [clbs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import clbs_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_KEEP, ST_LIMIT} state_t;

    cfg_t cfg;

    logic                in_valid_reg, in_valid_next;
    in_item_t            in_data_reg;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg, out_data_next;
    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   now_ms_reg, now_ms_next;
    logic [TIME_W-1:0]   last_poll_reg, last_poll_next;
    logic [TIME_W-1:0]   last_frame_reg, last_frame_next;
    logic [MAINS_W-1:0]  mains_reg [PHASE_COUNT];
    logic [MAINS_W-1:0]  mains_next [PHASE_COUNT];
    logic [CHARGER_W-1:0] charger_reg [PHASE_COUNT];
    logic [CHARGER_W-1:0] charger_next [PHASE_COUNT];
    logic signed [LIMIT_W-1:0] applied_reg, applied_next;
    logic [WORD_W-1:0]   limit_word_reg, limit_word_next;
    logic                link_reg, link_next;

    logic                advance;
    logic [MAINS_W-1:0]  mains_in [PHASE_COUNT];
    logic [CHARGER_W-1:0] charger_in [PHASE_COUNT];
    logic [FUSE_W-1:0]   balance_ma;
    logic [FUSE_W-1:0]   new_ma;
    logic [FUSE_W+RECIP_W-1:0] prod;
    logic [WORD_W-1:0]   amps;
    logic [TIME_W-1:0]   age;
    logic                enter_limit;
    logic                apply_en;
    logic [1:0]          issue;
    logic                changed;

    clbs_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clbs_limit_calc #(
        .PHASE_COUNT (PHASE_COUNT)
    ) u_limit_calc (
        .fuse_ma   (cfg.fuse_cap),
        .mains_ma  (mains_reg),
        .chg_cur   (charger_reg),
        .result_ma (balance_ma)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_comb begin
        for (int i = 0; i < PHASE_COUNT; i++) begin
            if (i == 0) begin
                mains_in[i]   = in_data_reg.mains_current_l1;
                charger_in[i] = swap16(in_data_reg.charger_word_l1);
            end else if (i == 1) begin
                mains_in[i]   = in_data_reg.mains_current_l2;
                charger_in[i] = swap16(in_data_reg.charger_word_l2);
            end else if (i == 2) begin
                mains_in[i]   = in_data_reg.mains_current_l3;
                charger_in[i] = swap16(in_data_reg.charger_word_l3);
            end else begin
                mains_in[i]   = '0;
                charger_in[i] = '0;
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        now_ms_next     = now_ms_reg;
        last_poll_next  = last_poll_reg;
        last_frame_next = last_frame_reg;
        mains_next      = mains_reg;
        charger_next    = charger_reg;
        applied_next    = applied_reg;
        limit_word_next = limit_word_reg;
        link_next       = link_reg;
        issue           = REQ_NONE;
        changed         = 1'b0;
        enter_limit     = 1'b0;
        apply_en        = 1'b0;
        new_ma          = '0;
        age             = now_ms_reg - last_frame_reg;

        unique case (in_data_reg.kind)
            KIND_TICK: begin
                now_ms_next = now_ms_reg + TIME_W'(1);
            end
            KIND_FRAME: begin
                mains_next      = mains_in;
                last_frame_next = now_ms_reg;
            end
            KIND_ANSWER: begin
                if (state_reg != ST_IDLE) begin
                    if (in_data_reg.answer_code == ANS_OK) begin
                        unique case (state_reg)
                            ST_READ: begin
                                charger_next = charger_in;
                                state_next   = ST_KEEP;
                                issue        = REQ_KEEP;
                            end
                            ST_KEEP: begin
                                state_next  = ST_LIMIT;
                                issue       = REQ_LIMIT;
                                enter_limit = 1'b1;
                            end
                            default: begin
                                changed    = !link_reg;
                                link_next  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        endcase
                    end else if (in_data_reg.answer_code == ANS_BUSY) begin
                        unique case (state_reg)
                            ST_READ:  issue = REQ_READ;
                            ST_KEEP:  issue = REQ_KEEP;
                            default: begin
                                issue       = REQ_LIMIT;
                                enter_limit = 1'b1;
                            end
                        endcase
                    end else begin
                        changed    = link_reg;
                        link_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: ;
        endcase

        if (enter_limit) begin
            if (age <= TIME_W'(cfg.poll_interval_ms)) begin
                apply_en = 1'b1;
                new_ma   = balance_ma;
            end else if (age >= TIME_W'(cfg.meter_timeout_ms)) begin
                apply_en = 1'b1;
            end
        end

        prod = {{RECIP_W{1'b0}}, new_ma} * {{FUSE_W{1'b0}}, MA_RECIP};
        amps = WORD_W'(prod >> DIV_SHIFT);

        if (apply_en && $signed({1'b0, new_ma}) != applied_reg) begin
            applied_next    = $signed({1'b0, new_ma});
            limit_word_next = swap16(amps);
        end

        if (in_data_reg.kind != KIND_RESERVED && state_next == ST_IDLE
            && (now_ms_next - last_poll_reg) >= TIME_W'(cfg.poll_interval_ms)) begin
            last_poll_next = now_ms_next;
            state_next     = ST_READ;
            issue          = REQ_READ;
        end

        out_data_next.issue_request     = issue;
        out_data_next.limit_word        = limit_word_next;
        out_data_next.limit_ma_now      = applied_next;
        out_data_next.connected         = link_next;
        out_data_next.connected_changed = changed;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= ST_IDLE;
            now_ms_reg     <= '0;
            last_poll_reg  <= '0;
            last_frame_reg <= LAST_FRAME_RESET;
            for (int i = 0; i < PHASE_COUNT; i++) begin
                mains_reg[i]   <= '0;
                charger_reg[i] <= '0;
            end
            applied_reg    <= '1;
            limit_word_reg <= '0;
            link_reg       <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg      <= state_next;
                now_ms_reg     <= now_ms_next;
                last_poll_reg  <= last_poll_next;
                last_frame_reg <= last_frame_next;
                mains_reg      <= mains_next;
                charger_reg    <= charger_next;
                applied_reg    <= applied_next;
                limit_word_reg <= limit_word_next;
                link_reg       <= link_next;
            end
        end
    end

endmodule

// ----- sv/clbs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// clbs_cfg_regs
// APB-style register file holding the fuse limit, poll interval and meter
// timeout.
// ----------------------------------------------------------------------------
module clbs_cfg_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [clbs_pkg::ADDR_W-1:0]  paddr,
    input  logic [clbs_pkg::DATA_W-1:0]  pwdata,
    output logic [clbs_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output clbs_pkg::cfg_t               cfg
);
    import clbs_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_index;
    logic       wr_en;

    assign reg_index = paddr[ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fuse_cap         <= FUSE_W'(FUSE_RESET);
            cfg_reg.poll_interval_ms <= IVAL_W'(POLL_RESET);
            cfg_reg.meter_timeout_ms <= IVAL_W'(METER_TIMEOUT_RESET);
        end else if (wr_en) begin
            unique case (reg_index)
                REG_FUSE:    cfg_reg.fuse_cap         <= pwdata[FUSE_W-1:0];
                REG_POLL:    cfg_reg.poll_interval_ms <= pwdata[IVAL_W-1:0];
                REG_TIMEOUT: cfg_reg.meter_timeout_ms <= pwdata[IVAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_FUSE:    prdata = DATA_W'(cfg_reg.fuse_cap);
            REG_POLL:    prdata = DATA_W'(cfg_reg.poll_interval_ms);
            REG_TIMEOUT: prdata = DATA_W'(cfg_reg.meter_timeout_ms);
            default:     prdata = '0;
        endcase
    end

endmodule

// ----- sv/clbs_limit_calc.sv -----
// ----------------------------------------------------------------------------
// clbs_limit_calc
// Balanced charge limit: minimum of the fuse and, over active phases (all when
// none is active), fuse minus mains plus charger current; clamped at zero.
// ----------------------------------------------------------------------------
module clbs_limit_calc #(
    parameter int PHASE_COUNT = clbs_pkg::PHASE_COUNT_DEF
) (
    input  logic [clbs_pkg::FUSE_W-1:0]    fuse_ma,
    input  logic [clbs_pkg::MAINS_W-1:0]   mains_ma [PHASE_COUNT],
    input  logic [clbs_pkg::CHARGER_W-1:0] chg_cur  [PHASE_COUNT],
    output logic [clbs_pkg::FUSE_W-1:0]    result_ma
);
    import clbs_pkg::*;

    logic [PHASE_COUNT-1:0]   active;
    logic signed [CAND_W-1:0] cand [PHASE_COUNT];
    logic signed [CAND_W-1:0] best;

    always_comb begin
        for (int i = 0; i < PHASE_COUNT; i++) begin
            active[i] = chg_cur[i] > CHARGER_W'(CHARGE_ON_THRESH);
            cand[i]   = $signed({2'b00, fuse_ma}) - $signed({2'b00, mains_ma[i]})
                        + $signed({3'b000, chg_cur[i]});
        end
        best = $signed({2'b00, fuse_ma});
        for (int i = 0; i < PHASE_COUNT; i++) begin
            if ((active == '0 || active[i]) && cand[i] < best) begin
                best = cand[i];
            end
        end
        result_ma = best[CAND_W-1] ? '0 : best[FUSE_W-1:0];
    end

endmodule

// ----- sv/clbs_checker.sv -----
// ----------------------------------------------------------------------------
// clbs_checker
// Port-level checks of the charger load-balance sequencer, bound to the top
// level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clbs_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input clbs_pkg::out_item_t m_data
);
    import clbs_pkg::*;

    `CLBS_ASSERT_NXT(a_result_holds, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_data))

    `CLBS_ASSERT_IMP(a_stall_only_on_output, aclk, aresetn, !s_ready,
        m_valid && !m_ready)

    `CLBS_ASSERT_IMP(a_link_change_no_write, aclk, aresetn,
        m_valid && m_data.connected_changed,
        m_data.issue_request != REQ_KEEP && m_data.issue_request != REQ_LIMIT)

    `CLBS_ASSERT_RST(a_reset_empty, aclk, aresetn, !m_valid && s_ready)

    `CLBS_ASSERT_IMP(a_unset_limit_word_zero, aclk, aresetn,
        m_valid && $signed(m_data.limit_ma_now) < 0,
        m_data.limit_word == '0 && $signed(m_data.limit_ma_now) == -18'sd1)

endmodule

bind charger_load_balance_sequencer_core clbs_checker u_clbs_checker (.*);

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the charger load-balance sequencer core. Directed tests cover
// ignored items, the poll sequence with busy retries, the limit choice and
// link failures. Random phases with changing register settings follow. A
// behavioral predictor computes every result, and a checker compares the
// result transactions with it under random gaps and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clbs_pkg::*;

    localparam logic [1:0] ANS_FAIL  = 2'd2;
    localparam logic [1:0] ANS_ABORT = 2'd3;

    localparam int FUSE_MAX     = 100000;
    localparam int IVAL_MAX     = 65535;
    localparam int ACTIVE_LIMIT = 1000;
    localparam int MA_PER_AMP   = 1000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES   = 10;

    typedef enum logic [1:0] {
        SEQ_IDLE  = REQ_NONE,
        SEQ_READ  = REQ_READ,
        SEQ_KEEP  = REQ_KEEP,
        SEQ_LIMIT = REQ_LIMIT
    } seq_state_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Predicted state of the sequencer.
    logic [FUSE_W-1:0]         fuse_ma;
    logic [IVAL_W-1:0]         poll_ms;
    logic [IVAL_W-1:0]         timeout_ms;
    seq_state_t                seq_state;
    logic [31:0]               clock_ms;
    logic [31:0]               poll_mark_ms;
    logic [31:0]               frame_ms;
    logic [MAINS_W-1:0]        mains_ma [3];
    logic [CHARGER_W-1:0]      chg_cur_ma [3];
    logic signed [LIMIT_W-1:0] applied_ma;
    logic [WORD_W-1:0]         limit_reg;
    logic                      link;

    out_item_t expected_results [$];

    int fail_count      = 0;
    int results_checked = 0;
    int items_sent      = 0;
    int polls_issued    = 0;
    int limit_writes    = 0;
    int link_changes    = 0;
    int reg_writes      = 0;
    int stall_cycles    = 0;

    bit hold_req  = 1'b0;
    int hold_left = 0;
    int unsigned rx_cycle = 0;

    charger_load_balance_sequencer_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    function automatic void load_defaults();
        fuse_ma      = 17'd25000;
        poll_ms      = 16'd1000;
        timeout_ms   = 16'd10000;
        seq_state    = SEQ_IDLE;
        clock_ms     = '0;
        poll_mark_ms = '0;
        frame_ms     = 32'd0 - 32'd10000;
        for (int i = 0; i < 3; i++) begin
            mains_ma[i]   = '0;
            chg_cur_ma[i] = '0;
        end
        applied_ma = -18'sd1;
        limit_reg  = '0;
        link       = 1'b0;
    endfunction

    function automatic logic signed [LIMIT_W-1:0] balanced_limit();
        int best;
        int cand;
        bit any_active;
        best = int'(fuse_ma);
        any_active = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (chg_cur_ma[i] > ACTIVE_LIMIT) any_active = 1'b1;
        end
        for (int i = 0; i < 3; i++) begin
            cand = int'(fuse_ma) - int'(mains_ma[i]) + int'(chg_cur_ma[i]);
            if ((!any_active || chg_cur_ma[i] > ACTIVE_LIMIT) && cand < best) best = cand;
        end
        if (best < 0) best = 0;
        return LIMIT_W'(best);
    endfunction

    function automatic void apply_limit(input logic signed [LIMIT_W-1:0] ma);
        logic [15:0] amps;
        if (ma == applied_ma) return;
        applied_ma = ma;
        amps = 16'(ma / MA_PER_AMP);
        limit_reg = {amps[7:0], amps[15:8]};
    endfunction

    function automatic logic [1:0] enter_state(input seq_state_t st);
        logic [31:0] age;
        seq_state = st;
        if (st == SEQ_LIMIT) begin
            age = clock_ms - frame_ms;
            if (age <= poll_ms) apply_limit(balanced_limit());
            else if (age >= timeout_ms) apply_limit('0);
        end
        return st;
    endfunction

    function automatic out_item_t predict_result(input in_item_t it);
        out_item_t r;
        logic [1:0] issue;
        logic changed;
        issue = REQ_NONE;
        changed = 1'b0;
        case (it.kind)
            KIND_TICK: begin
                clock_ms = clock_ms + 32'd1;
            end
            KIND_FRAME: begin
                mains_ma[0] = it.mains_current_l1;
                mains_ma[1] = it.mains_current_l2;
                mains_ma[2] = it.mains_current_l3;
                frame_ms = clock_ms;
            end
            KIND_ANSWER: begin
                if (seq_state != SEQ_IDLE) begin
                    if (it.answer_code == ANS_OK) begin
                        case (seq_state)
                            SEQ_READ: begin
                                chg_cur_ma[0] = {it.charger_word_l1[7:0], it.charger_word_l1[15:8]};
                                chg_cur_ma[1] = {it.charger_word_l2[7:0], it.charger_word_l2[15:8]};
                                chg_cur_ma[2] = {it.charger_word_l3[7:0], it.charger_word_l3[15:8]};
                                issue = enter_state(SEQ_KEEP);
                            end
                            SEQ_KEEP: begin
                                issue = enter_state(SEQ_LIMIT);
                            end
                            default: begin
                                changed = !link;
                                link = 1'b1;
                                void'(enter_state(SEQ_IDLE));
                            end
                        endcase
                    end else if (it.answer_code == ANS_BUSY) begin
                        issue = enter_state(seq_state);
                    end else begin
                        changed = link;
                        link = 1'b0;
                        void'(enter_state(SEQ_IDLE));
                    end
                end
            end
            default: begin
            end
        endcase
        if (it.kind != KIND_RESERVED && seq_state == SEQ_IDLE
            && clock_ms - poll_mark_ms >= poll_ms) begin
            poll_mark_ms = clock_ms;
            issue = enter_state(SEQ_READ);
        end
        r.issue_request     = issue;
        r.limit_word        = limit_reg;
        r.limit_ma_now      = applied_ma;
        r.connected         = link;
        r.connected_changed = changed;
        return r;
    endfunction

    function automatic in_item_t make_item(input logic [1:0] kind);
        in_item_t it;
        it.kind             = kind;
        it.mains_current_l1 = MAINS_W'($urandom);
        it.mains_current_l2 = MAINS_W'($urandom);
        it.mains_current_l3 = MAINS_W'($urandom);
        it.answer_code      = 2'($urandom);
        it.charger_word_l1  = CHARGER_W'($urandom);
        it.charger_word_l2  = CHARGER_W'($urandom);
        it.charger_word_l3  = CHARGER_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_answer(input logic [1:0] code, input logic [15:0] w1,
                                             input logic [15:0] w2, input logic [15:0] w3);
        in_item_t it;
        it = make_item(KIND_ANSWER);
        it.answer_code     = code;
        it.charger_word_l1 = w1;
        it.charger_word_l2 = w2;
        it.charger_word_l3 = w3;
        return it;
    endfunction

    function automatic logic [15:0] random_charger_word();
        logic [15:0] cur;
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: cur = 16'($urandom_range(0, ACTIVE_LIMIT));
            default: cur = 16'($urandom_range(ACTIVE_LIMIT + 1, 32000));
        endcase
        return {cur[7:0], cur[15:8]};
    endfunction

    // Mostly well-formed poll sequences: answers while a request is open,
    // ticks and frames while idle, with some noise mixed in.
    function automatic in_item_t random_item();
        in_item_t it;
        int pick;
        pick = $urandom_range(0, 99);
        if (seq_state == SEQ_IDLE) begin
            it = make_item(pick < 72 ? KIND_TICK : pick < 92 ? KIND_FRAME :
                           pick < 96 ? KIND_ANSWER : KIND_RESERVED);
        end else begin
            it = make_item(pick < 58 ? KIND_ANSWER : pick < 82 ? KIND_TICK :
                           pick < 97 ? KIND_FRAME : KIND_RESERVED);
        end
        if (it.kind == KIND_FRAME && $urandom_range(0, 2) != 0) begin
            it.mains_current_l1 = MAINS_W'($urandom_range(0, fuse_ma));
            it.mains_current_l2 = MAINS_W'($urandom_range(0, fuse_ma));
            it.mains_current_l3 = MAINS_W'($urandom_range(0, fuse_ma));
        end
        if (it.kind == KIND_ANSWER) begin
            pick = $urandom_range(0, 99);
            it.answer_code = pick < 80 ? ANS_OK : pick < 92 ? ANS_BUSY :
                             pick < 97 ? ANS_FAIL : ANS_ABORT;
            it.charger_word_l1 = random_charger_word();
            it.charger_word_l2 = random_charger_word();
            it.charger_word_l3 = random_charger_word();
        end
        return it;
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic send_item(input in_item_t it);
        out_item_t r;
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        r = predict_result(it);
        expected_results.push_back(r);
        items_sent++;
        if (r.issue_request == REQ_READ) polls_issued++;
        if (r.issue_request == REQ_LIMIT) limit_writes++;
        if (r.connected_changed) link_changes++;
    endtask

    task automatic idle_input(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic write, input logic [1:0] index,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        logic [31:0] rd;
        logic [31:0] mask;
        mask = (index == REG_FUSE) ? 32'h1FFFF : 32'hFFFF;
        apb_access(1'b1, index, value, rd);
        case (index)
            REG_FUSE:    fuse_ma    = value[FUSE_W-1:0];
            REG_POLL:    poll_ms    = value[IVAL_W-1:0];
            REG_TIMEOUT: timeout_ms = value[IVAL_W-1:0];
            default: begin
            end
        endcase
        apb_access(1'b0, index, '0, rd);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        reg_writes++;
        if ((rd & mask) !== (value & mask)) begin
            $error("register %0d: expected %0d, actual %0d", index, value & mask, rd & mask);
            fail_count++;
        end
    endtask

    task automatic run_random(input int count);
        in_item_t it;
        int done;
        int burst;
        done = 0;
        burst = 0;
        while (done < count) begin
            if (burst == 0) begin
                if ($urandom_range(0, 4) != 0) idle_input($urandom_range(1, 8));
                burst = $urandom_range(1, 24);
            end
            it = random_item();
            if (it.kind != KIND_RESERVED && !(it.kind == KIND_ANSWER && seq_state == SEQ_IDLE))
                done++;
            send_item(it);
            burst--;
        end
    endtask

    task automatic test_ignored_items();
        in_item_t it;
        send_item(make_item(KIND_RESERVED));
        send_item(make_answer(ANS_OK, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_answer(ANS_FAIL, 16'h0000, 16'h0000, 16'h0000));
        it = make_item(KIND_FRAME);
        it.mains_current_l1 = '1;
        it.mains_current_l2 = '1;
        it.mains_current_l3 = '1;
        send_item(it);
        send_item(make_item(KIND_TICK));
        send_item(make_item(KIND_TICK));
        drain();
    endtask

    task automatic test_poll_sequence();
        in_item_t it;
        write_register(REG_POLL, 2);
        write_register(REG_TIMEOUT, IVAL_MAX);
        write_register(REG_FUSE, FUSE_MAX);
        send_item(make_item(KIND_TICK));
        send_item(make_answer(ANS_BUSY, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(KIND_TICK));
        send_item(make_answer(ANS_OK, 16'hFFFF, 16'h0000, 16'hE903));
        // The frame is neither fresh nor stale here, so the unset limit stays.
        send_item(make_answer(ANS_OK, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_answer(ANS_OK, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_item(KIND_TICK));
        send_item(make_answer(ANS_OK, 16'h0000, 16'h0000, 16'h0000));
        it = make_item(KIND_FRAME);
        it.mains_current_l1 = '0;
        it.mains_current_l2 = '0;
        it.mains_current_l3 = '0;
        send_item(it);
        send_item(make_answer(ANS_OK, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_answer(ANS_OK, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic test_link_failure();
        send_item(make_item(KIND_TICK));
        send_item(make_item(KIND_TICK));
        send_item(make_item(KIND_TICK));
        send_item(make_item(KIND_TICK));
        // The failure returns to idle late enough to start a new poll at once.
        send_item(make_answer(ANS_FAIL, 16'h0000, 16'h0000, 16'h0000));
        send_item(make_answer(ANS_ABORT, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(make_item(KIND_TICK));
        send_item(make_item(KIND_TICK));
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++) send_item(random_item());
        drain();
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            case (phase)
                0: begin
                    write_register(REG_FUSE, 25000);
                    write_register(REG_POLL, 1);
                    write_register(REG_TIMEOUT, 3);
                end
                1: begin
                    write_register(REG_FUSE, 0);
                    write_register(REG_POLL, 2);
                    write_register(REG_TIMEOUT, IVAL_MAX);
                end
                2: begin
                    write_register(REG_FUSE, FUSE_MAX);
                    write_register(REG_POLL, 3);
                    write_register(REG_TIMEOUT, 1);
                end
                3: begin
                    write_register(REG_FUSE, $urandom_range(0, FUSE_MAX));
                    write_register(REG_POLL, $urandom_range(1, 6));
                    write_register(REG_TIMEOUT, $urandom_range(1, 16));
                end
                4: begin
                    write_register(REG_FUSE, $urandom_range(0, FUSE_MAX));
                    write_register(REG_POLL, 1);
                    write_register(REG_TIMEOUT, $urandom_range(2, 8));
                end
                default: begin
                    write_register(REG_POLL, IVAL_MAX);
                    write_register(REG_TIMEOUT, 10);
                end
            endcase
            run_random(phase < 5 ? 250 : 40);
        end
    endtask

    // Receiver: a changing stall pattern, plus long hold-offs on request.
    always @(posedge aclk) begin
        rx_cycle++;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            case ((rx_cycle / 256) % 4)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= (rx_cycle % 7) < 4;
                default: m_ready <= $urandom_range(0, 9) < 3;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && !s_ready) stall_cycles++;
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with no expected result");
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                check_field("issue_request", want.issue_request, m_data.issue_request);
                check_field("limit_word", want.limit_word, m_data.limit_word);
                check_field("limit_ma_now", want.limit_ma_now, m_data.limit_ma_now);
                check_field("connected", want.connected, m_data.connected);
                check_field("connected_changed", want.connected_changed,
                            m_data.connected_changed);
                results_checked++;
            end
        end
    end

    initial begin
        #4_800_000;
        $display("Timeout before the run could finish.");
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        load_defaults();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_ignored_items();
        test_poll_sequence();
        test_link_failure();
        test_backpressure();
        test_random_phases();
        drain();
        repeat (END_CYCLES) @(posedge aclk);
        $display("Checked %0d of %0d transactions: %0d polls, %0d limit writes, %0d link changes.",
                 results_checked, items_sent, polls_issued, limit_writes, link_changes);
        $display("Register writes: %0d; cycles with the input held off: %0d.",
                 reg_writes, stall_cycles);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/clbs_pkg.sv
sv/clbs_cfg_regs.sv
sv/clbs_limit_calc.sv
sv/charger_load_balance_sequencer_core.sv
sv/clbs_checker.sv
dv/tb_top.sv
